// ===== rtl/tlil_pkg.sv =====
// Package for the text line index and lookup block.
// Holds default sizes, codes, byte constants and the controller/datapath interface types.
// No dependencies.
package tlil_pkg;

    // Default sizes
    localparam int MAX_LINES_DEF   = 1024;
    localparam int OFFSET_BITS_DEF = 20;

    // Transaction kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_POS   = 2'd2;
    localparam logic [1:0] KIND_LINE  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_OFFSET   = 2'd1;
    localparam logic [1:0] ERR_LINE     = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // Byte order mark and line terminators
    localparam logic [7:0] BOM_B0  = 8'hEF;
    localparam logic [7:0] BOM_B1  = 8'hBB;
    localparam logic [7:0] BOM_B2  = 8'hBF;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Byte order mark progress
    localparam logic [1:0] BOM_NONE = 2'd0;
    localparam logic [1:0] BOM_EF   = 2'd1;
    localparam logic [1:0] BOM_EFBB = 2'd2;
    localparam logic [1:0] BOM_DONE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS_ISSUE,
        S_POS_WAIT,
        S_SPAN_A,
        S_SPAN_B,
        S_SPAN_C
    } state_t;

    // Table read address source
    typedef enum logic [1:0] {
        RA_MID,
        RA_LINE,
        RA_NEXT
    } rd_sel_t;

    // Which result to load into the output registers
    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_ERR,
        FIN_POS,
        FIN_SPAN_LAST,
        FIN_SPAN_NEXT
    } fin_t;

    typedef struct packed {
        logic    clear;
        logic    take_byte;
        logic    load_query;
        rd_sel_t rd_sel;
        logic    search_step;
        logic    span_capture;
        fin_t    finish;
    } cmd_t;

    typedef struct packed {
        logic query_err;
        logic search_done;
        logic line_is_last;
    } status_t;

endpackage

// ===== rtl/tlil_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tlil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tlil_ctrl.sv =====
// Controller state machine: accepts transactions, sequences the binary search
// and the span reads. Depends on tlil_pkg.
module tlil_ctrl import tlil_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] kind,
    input  status_t    status,
    output cmd_t       cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '{clear: 1'b0, take_byte: 1'b0, load_query: 1'b0, rd_sel: RA_MID,
                       search_step: 1'b0, span_capture: 1'b0, finish: FIN_NONE};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_CLEAR: cmd.clear     = 1'b1;
                        KIND_BYTE:  cmd.take_byte = 1'b1;
                        KIND_POS, KIND_LINE:
                        begin
                            cmd.load_query = 1'b1;
                            if (status.query_err)
                            begin
                                cmd.finish = FIN_ERR;
                            end
                            else if (kind == KIND_POS)
                            begin
                                state_next = S_POS_ISSUE;
                            end
                            else
                            begin
                                state_next = S_SPAN_A;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_POS_ISSUE:
            begin
                if (status.search_done)
                begin
                    cmd.finish = FIN_POS;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RA_MID;
                    state_next = S_POS_WAIT;
                end
            end
            S_POS_WAIT:
            begin
                cmd.search_step = 1'b1;
                state_next      = S_POS_ISSUE;
            end
            S_SPAN_A:
            begin
                cmd.rd_sel = RA_LINE;
                state_next = S_SPAN_B;
            end
            S_SPAN_B:
            begin
                if (status.line_is_last)
                begin
                    cmd.finish = FIN_SPAN_LAST;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.span_capture = 1'b1;
                    cmd.rd_sel       = RA_NEXT;
                    state_next       = S_SPAN_C;
                end
            end
            S_SPAN_C:
            begin
                cmd.finish = FIN_SPAN_NEXT;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/tlil_dp.sv =====
// Datapath: text scanner, line start and CRLF tables, search registers and
// result registers. Depends on tlil_pkg and tlil_ram.
module tlil_dp import tlil_pkg::*; #(
    parameter int MAX_LINES   = MAX_LINES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cmd_t                             cmd,
    output status_t                          status,
    input  logic [1:0]                       kind,
    input  logic [7:0]                       text_byte,
    input  logic [OFFSET_BITS-1:0]           query_offset,
    input  logic [$clog2(MAX_LINES)-1:0]     query_line,
    output logic                             done,
    output logic [$clog2(MAX_LINES)-1:0]     row,
    output logic [OFFSET_BITS-1:0]           column,
    output logic [OFFSET_BITS-1:0]           span_start,
    output logic [OFFSET_BITS-1:0]           span_end,
    output logic [$clog2(MAX_LINES):0]       lines_known,
    output logic [1:0]                       error_code
);

    localparam int LB  = $clog2(MAX_LINES);
    localparam int LKB = LB + 1;
    localparam int OB  = OFFSET_BITS;
    localparam logic [LKB-1:0] LINE_LIMIT = LKB'(MAX_LINES);

    // Text state
    logic [LKB-1:0] line_total_reg,  line_total_next;
    logic [OB-1:0]  text_length_reg, text_length_next;
    logic [1:0]     bom_reg,         bom_next;
    logic           after_cr_reg,    after_cr_next;
    logic           overflow_reg,    overflow_next;

    // Query state
    logic [OB-1:0]  off_reg;
    logic [LB-1:0]  ln_reg;
    logic [LB-1:0]  lo_reg;
    logic [LB-1:0]  hi_reg;
    logic [OB-1:0]  lo_start_reg;
    logic [OB-1:0]  start_reg;
    logic           crlf_reg;

    // Result registers
    logic           done_reg;
    logic [LB-1:0]  row_reg;
    logic [OB-1:0]  column_reg;
    logic [OB-1:0]  span_start_reg;
    logic [OB-1:0]  span_end_reg;
    logic [LKB-1:0] lines_known_reg;
    logic [1:0]     error_code_reg;

    // Table ports
    logic           tbl_we;
    logic [LB-1:0]  start_waddr;
    logic [LB-1:0]  crlf_waddr;
    logic [OB-1:0]  start_wdata;
    logic           crlf_wdata;
    logic [LB-1:0]  rd_addr;
    logic [OB-1:0]  rd_start;
    logic           rd_crlf;

    logic [LKB-1:0] mid_wide;
    logic [LB-1:0]  mid;
    logic [LKB-1:0] ln_plus1;
    logic [1:0]     err_now;
    logic [OB-1:0]  pos;
    logic           open_line;
    logic [OB-1:0]  rd_start_eff;
    logic [OB-1:0]  end_raw;
    logic [OB-1:0]  end_adj;

    tlil_ram #(.WIDTH(OB), .DEPTH(MAX_LINES)) u_start_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (start_waddr),
        .wdata (start_wdata),
        .raddr (rd_addr),
        .rdata (rd_start)
    );

    tlil_ram #(.WIDTH(1), .DEPTH(MAX_LINES)) u_crlf_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (crlf_waddr),
        .wdata (crlf_wdata),
        .raddr (rd_addr),
        .rdata (rd_crlf)
    );

    // Search midpoint, upper half rounded up
    assign mid_wide = {1'b0, lo_reg} + ((({1'b0, hi_reg} - {1'b0, lo_reg}) + LKB'(1)) >> 1);
    assign mid      = mid_wide[LB-1:0];
    assign ln_plus1 = {1'b0, ln_reg} + LKB'(1);

    // Table read address
    always_comb
    begin
        case (cmd.rd_sel)
            RA_MID:  rd_addr = mid;
            RA_LINE: rd_addr = ln_reg;
            RA_NEXT: rd_addr = ln_plus1[LB-1:0];
            default: rd_addr = mid;
        endcase
    end

    // Error check on the incoming query; overflow wins
    always_comb
    begin
        if (overflow_reg)
        begin
            err_now = ERR_OVERFLOW;
        end
        else if (kind == KIND_POS)
        begin
            err_now = (query_offset > text_length_reg) ? ERR_OFFSET : ERR_OK;
        end
        else
        begin
            err_now = ({1'b0, query_line} >= line_total_reg) ? ERR_LINE : ERR_OK;
        end
    end

    assign status.query_err    = (err_now != ERR_OK);
    assign status.search_done  = (lo_reg >= hi_reg);
    assign status.line_is_last = (ln_plus1 >= line_total_reg);

    // Byte scanner: BOM drop, line terminators, table writes
    always_comb
    begin
        line_total_next  = line_total_reg;
        text_length_next = text_length_reg;
        bom_next         = bom_reg;
        after_cr_next    = after_cr_reg;
        overflow_next    = overflow_reg;
        tbl_we           = 1'b0;
        open_line        = 1'b0;
        pos              = text_length_reg;
        start_waddr      = line_total_reg[LB-1:0];
        crlf_waddr       = line_total_reg[LB-1:0] - LB'(1);
        start_wdata      = text_length_reg + OB'(1);
        crlf_wdata       = 1'b0;

        if (cmd.clear)
        begin
            line_total_next  = LKB'(1);
            text_length_next = '0;
            bom_next         = BOM_NONE;
            after_cr_next    = 1'b0;
            overflow_next    = 1'b0;
        end
        else if (cmd.take_byte && !(&text_length_reg))
        begin
            text_length_next = pos + OB'(1);
            case (bom_reg)
                BOM_NONE: bom_next = (text_byte == BOM_B0) ? BOM_EF : BOM_DONE;
                BOM_EF:   bom_next = (text_byte == BOM_B1) ? BOM_EFBB : BOM_DONE;
                BOM_EFBB: bom_next = BOM_DONE;
                default:  bom_next = bom_reg;
            endcase

            if (bom_reg == BOM_EFBB && text_byte == BOM_B2)
            begin
                // complete mark: restart the text
                text_length_next = '0;
            end
            else if (text_byte == CHAR_LF)
            begin
                after_cr_next = 1'b0;
                if (after_cr_reg)
                begin
                    // CRLF: fix up the line opened by the CR
                    if (!overflow_reg)
                    begin
                        tbl_we      = 1'b1;
                        start_waddr = line_total_reg[LB-1:0] - LB'(1);
                        crlf_waddr  = line_total_reg[LB-1:0] - LB'(2);
                        crlf_wdata  = 1'b1;
                    end
                end
                else
                begin
                    open_line = 1'b1;
                end
            end
            else if (text_byte == CHAR_CR)
            begin
                after_cr_next = 1'b1;
                open_line     = 1'b1;
            end
            else
            begin
                after_cr_next = 1'b0;
            end

            if (open_line)
            begin
                if (line_total_reg >= LINE_LIMIT)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    tbl_we          = 1'b1;
                    line_total_next = line_total_reg + LKB'(1);
                end
            end
        end
    end

    // Entry 0 always starts at offset 0
    assign rd_start_eff = (ln_reg == '0) ? '0 : rd_start;
    assign end_raw      = rd_start - OB'(1);
    assign end_adj      = (crlf_reg && end_raw != '0) ? end_raw - OB'(1) : end_raw;

    // Text state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_total_reg  <= LKB'(1);
            text_length_reg <= '0;
            bom_reg         <= BOM_NONE;
            after_cr_reg    <= 1'b0;
            overflow_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            line_total_reg  <= line_total_next;
            text_length_reg <= text_length_next;
            bom_reg         <= bom_next;
            after_cr_reg    <= after_cr_next;
            overflow_reg    <= overflow_next;
            done_reg        <= (cmd.finish != FIN_NONE);
        end
    end

    // Query and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            off_reg      <= query_offset;
            ln_reg       <= query_line;
            lo_reg       <= '0;
            hi_reg       <= LB'(line_total_reg - LKB'(1));
            lo_start_reg <= '0;
        end
        else if (cmd.search_step)
        begin
            if (rd_start <= off_reg)
            begin
                lo_reg       <= mid;
                lo_start_reg <= rd_start;
            end
            else
            begin
                hi_reg <= mid - LB'(1);
            end
        end
        if (cmd.span_capture)
        begin
            start_reg <= rd_start_eff;
            crlf_reg  <= rd_crlf;
        end
    end

    // Result registers; fields not used by a result read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.finish != FIN_NONE)
        begin
            lines_known_reg <= line_total_reg;
            case (cmd.finish)
                FIN_ERR:
                begin
                    row_reg        <= '0;
                    column_reg     <= '0;
                    span_start_reg <= '0;
                    span_end_reg   <= '0;
                    error_code_reg <= err_now;
                end
                FIN_POS:
                begin
                    row_reg        <= lo_reg;
                    column_reg     <= off_reg - lo_start_reg;
                    span_start_reg <= '0;
                    span_end_reg   <= '0;
                    error_code_reg <= ERR_OK;
                end
                FIN_SPAN_LAST:
                begin
                    row_reg        <= '0;
                    column_reg     <= '0;
                    span_start_reg <= rd_start_eff;
                    span_end_reg   <= text_length_reg;
                    error_code_reg <= ERR_OK;
                end
                FIN_SPAN_NEXT:
                begin
                    row_reg        <= '0;
                    column_reg     <= '0;
                    span_start_reg <= start_reg;
                    span_end_reg   <= end_adj;
                    error_code_reg <= ERR_OK;
                end
                default:
                begin
                    row_reg        <= '0;
                    column_reg     <= '0;
                    span_start_reg <= '0;
                    span_end_reg   <= '0;
                    error_code_reg <= ERR_OK;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign row         = row_reg;
    assign column      = column_reg;
    assign span_start  = span_start_reg;
    assign span_end    = span_end_reg;
    assign lines_known = lines_known_reg;
    assign error_code  = error_code_reg;

endmodule

// ===== rtl/text_line_index_and_lookup.sv =====
// Top level of the text line index and lookup block.
// Depends on tlil_pkg, tlil_ctrl, tlil_dp (which holds two tlil_ram tables).
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | start, busy        | kind, text_byte, query_offset, query_line
//  result   | done (1-cycle)     | row, column, span_start, span_end,
//           |                    | lines_known, error_code
//
// Clear and text byte transactions give no result; the next transaction may
// follow in the next cycle. A position query runs a binary search over the line
// start table, each step a table read plus a compare; a line query reads the start
// table once for the last line and twice otherwise. A failing query finishes from
// idle without raising busy. The result shows in the first cycle with busy low,
// with done high for one cycle only: the receiver cannot stall.
// Reset is asynchronous; after it the text is empty with one line.
module text_line_index_and_lookup import tlil_pkg::*; #(
    parameter int MAX_LINES   = MAX_LINES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       kind,
    input  logic [7:0]                       text_byte,
    input  logic [OFFSET_BITS-1:0]           query_offset,
    input  logic [$clog2(MAX_LINES)-1:0]     query_line,
    output logic                             done,
    output logic [$clog2(MAX_LINES)-1:0]     row,
    output logic [OFFSET_BITS-1:0]           column,
    output logic [OFFSET_BITS-1:0]           span_start,
    output logic [OFFSET_BITS-1:0]           span_end,
    output logic [$clog2(MAX_LINES):0]       lines_known,
    output logic [1:0]                       error_code
);

    cmd_t    cmd;
    status_t status;

    tlil_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tlil_dp #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .text_byte    (text_byte),
        .query_offset (query_offset),
        .query_line   (query_line),
        .done         (done),
        .row          (row),
        .column       (column),
        .span_start   (span_start),
        .span_end     (span_end),
        .lines_known  (lines_known),
        .error_code   (error_code)
    );

endmodule
